### src/cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the compacting block suballocator.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int NumHandles = 1024;
  localparam int AddrW      = $clog2(NumHandles);
  localparam int KbW        = 16;
  localparam int HandleW    = 11;
  localparam int CfgIdxW    = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRegionPresent = 1'b0,
    CfgCapacityKb    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FnAlloc  = 2'd0,
    FnFree   = 2'd1,
    FnQuery  = 2'd2,
    FnVerify = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic [KbW-1:0]     size_kb;
    logic [HandleW-1:0] handle;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [HandleW-1:0] handle_out;
    logic [KbW-1:0]     total_kb_out;
    logic [KbW-1:0]     free_kb;
    logic               move_needed;
    logic [KbW-1:0]     move_src_kb;
    logic [KbW-1:0]     move_dst_kb;
    logic [KbW-1:0]     move_len_kb;
  } res_t;

  typedef struct packed {
    logic           region_present;
    logic [KbW-1:0] capacity_kb;
  } cfg_t;

  typedef struct packed {
    logic [KbW-1:0] size_kb;
    logic [KbW-1:0] offset_kb;
  } entry_t;

endpackage

### src/cbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbs_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/cbs_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_seq
// Sequencer: clears the handle table, runs lookups, free-slot scans and
// compaction sweeps over the table memory, and builds one result per item.
// ----------------------------------------------------------------------------
module cbs_seq
  import cbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_i,
  output logic res_valid_o,
  input  logic res_taken_i,
  output res_t res_o
);

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StCheck = 7'b0000100,
    StScan  = 7'b0001000,
    StSweep = 7'b0010000,
    StResp  = 7'b0100000,
    StSpare = 7'b1000000
  } state_e;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(NumHandles - 1);

  state_e             state_q, state_d;
  logic [AddrW-1:0]   cnt_q, cnt_d;
  logic               issue_q, issue_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]   rd_addr_q, rd_addr_d;
  logic [KbW-1:0]     used_q, used_d;
  req_t               req_q, req_d;
  logic [AddrW-1:0]   slot_q, slot_d;
  logic [KbW-1:0]     off_q, off_d;
  logic [KbW-1:0]     sz_q, sz_d;
  res_t               res_q, res_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [AddrW-1:0]   ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t             rd_entry;

  logic               accept;
  logic               handle_ok;
  logic               room_ok;
  logic [KbW-1:0]     top_kb;
  logic [KbW-1:0]     len_kb;

  cbs_ram #(
    .Depth(NumHandles),
    .Width($bits(entry_t))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry    = entry_t'(ram_rdata);
  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == StResp);
  assign res_o       = res_q;

  assign handle_ok = cfg_i.region_present && (in_i.handle != '0) &&
                     (32'(in_i.handle) <= NumHandles);
  assign room_ok   = cfg_i.region_present && (used_q <= cfg_i.capacity_kb) &&
                     ({1'b0, in_i.size_kb} <= ({1'b0, cfg_i.capacity_kb} - {1'b0, used_q}));
  assign top_kb    = rd_entry.offset_kb + rd_entry.size_kb;
  assign len_kb    = used_q - top_kb;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    issue_d   = issue_q;
    rd_vld_d  = 1'b0;
    rd_addr_d = rd_addr_q;
    used_d    = used_q;
    req_d     = req_q;
    slot_d    = slot_q;
    off_d     = off_q;
    sz_d      = sz_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_raddr = cnt_q;

    if ((state_q == StScan || state_q == StSweep) && issue_q) begin
      rd_vld_d  = 1'b1;
      rd_addr_d = cnt_q;
      cnt_d     = cnt_q + AddrW'(1);
      if (cnt_q == LastAddr) begin
        issue_d = 1'b0;
      end
    end

    unique case (state_q)
      StClear: begin
        ram_we = 1'b1;
        cnt_d  = cnt_q + AddrW'(1);
        if (cnt_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        ram_raddr = AddrW'(32'(in_i.handle) - 1);
        if (accept) begin
          req_d  = in_i;
          slot_d = AddrW'(32'(in_i.handle) - 1);
          res_d  = '0;
          cnt_d  = '0;
          unique case (in_i.func)
            FnAlloc: begin
              if (room_ok) begin
                issue_d = 1'b1;
                state_d = StScan;
              end else begin
                state_d = StResp;
              end
            end
            FnFree, FnVerify: begin
              state_d = handle_ok ? StCheck : StResp;
            end
            FnQuery: begin
              res_d.total_kb_out = cfg_i.capacity_kb;
              res_d.free_kb = (used_q <= cfg_i.capacity_kb) ?
                              (cfg_i.capacity_kb - used_q) : '0;
              state_d = StResp;
            end
            default: state_d = StResp;
          endcase
        end
      end
      StCheck: begin
        if (rd_entry.size_kb == '0) begin
          state_d = StResp;
        end else if (req_q.func == FnVerify) begin
          res_d.ok = 1'b1;
          state_d  = StResp;
        end else begin
          res_d.ok = 1'b1;
          if (len_kb != '0) begin
            res_d.move_needed = 1'b1;
            res_d.move_src_kb = top_kb;
            res_d.move_dst_kb = rd_entry.offset_kb;
            res_d.move_len_kb = len_kb;
          end
          used_d    = used_q - rd_entry.size_kb;
          off_d     = rd_entry.offset_kb;
          sz_d      = rd_entry.size_kb;
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          ram_wdata = '{size_kb: '0, offset_kb: rd_entry.offset_kb};
          cnt_d     = '0;
          issue_d   = 1'b1;
          state_d   = StSweep;
        end
      end
      StScan: begin
        if (rd_vld_q) begin
          if (rd_entry.size_kb == '0) begin
            ram_we           = 1'b1;
            ram_waddr        = rd_addr_q;
            ram_wdata        = '{size_kb: req_q.size_kb, offset_kb: used_q};
            used_d           = used_q + req_q.size_kb;
            res_d.ok         = 1'b1;
            res_d.handle_out = HandleW'(32'(rd_addr_q) + 1);
            issue_d          = 1'b0;
            rd_vld_d         = 1'b0;
            state_d          = StResp;
          end else if (rd_addr_q == LastAddr) begin
            issue_d  = 1'b0;
            rd_vld_d = 1'b0;
            state_d  = StResp;
          end
        end
      end
      StSweep: begin
        if (rd_vld_q) begin
          if (rd_entry.size_kb != '0 && rd_entry.offset_kb > off_q) begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr_q;
            ram_wdata = '{size_kb: rd_entry.size_kb, offset_kb: rd_entry.offset_kb - sz_q};
          end
          if (rd_addr_q == LastAddr) begin
            issue_d  = 1'b0;
            rd_vld_d = 1'b0;
            state_d  = StResp;
          end
        end
      end
      StResp: begin
        if (res_taken_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      cnt_q    <= '0;
      issue_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      used_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    req_q     <= req_d;
    slot_q    <= slot_d;
    off_q     <= off_d;
    sz_q      <= sz_d;
    res_q     <= res_d;
  end

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle || state_q == StResp) |-> !ram_we)
    else $error("table written outside a table pass");

  a_rd_vld_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == StScan || state_q == StSweep))
    else $error("read data pending outside a scan or sweep");

  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.ok) |-> (res_o.handle_out == '0))
    else $error("failed item carries a handle");

  a_query_keeps_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.func == FnQuery || in_i.func == FnVerify)) |=> $stable(used_q))
    else $error("used mark moved on query or verify");

endmodule

### src/compacting_block_suballocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_block_suballocator_core
// Handle table allocator that keeps all live blocks packed from offset zero.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry handle table to zero, one entry
// a cycle, and accepts no item until that sweep ends; configuration writes are
// taken throughout. Items are processed one at a time through the table
// memory's single read port. Query and items rejected on the handle range
// or on room go straight to the result; verify and a free of an unused slot
// first read the slot's entry, an allocate scans the table for the first
// free slot, and a successful free sweeps the whole table to shift offsets
// down. A finished result sits in an output register, so the next item can
// be accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module compacting_block_suballocator_core
  import cbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [KbW-1:0]     cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output res_t               out_o
);

  cfg_t cfg_q, cfg_d;
  logic out_valid_q, out_valid_d;
  res_t out_q;
  logic res_valid;
  logic res_taken;
  res_t res;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRegionPresent: cfg_d.region_present = cfg_data_i[0];
        CfgCapacityKb:    cfg_d.capacity_kb    = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  cbs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .res_valid_o(res_valid),
    .res_taken_i(res_taken),
    .res_o      (res)
  );

  assign res_taken   = res_valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = res_taken || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      out_q <= res;
    end
  end

endmodule

### dv/cbs_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_alloc_checker
// Watches the configuration port and both item channels of the suballocator,
// keeps its own copy of the handle table, the used mark and the registers,
// predicts the result of every accepted item and compares each returned
// result field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cbs_alloc_checker
  import cbs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [KbW-1:0]     cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  req_t               in_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  res_t               out_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [KbW-1:0] slot_size_kb   [NumHandles];
  logic [KbW-1:0] slot_offset_kb [NumHandles];
  logic [KbW-1:0] used_kb;
  logic           region_present;
  logic [KbW-1:0] capacity_kb;
  res_t           expected_res_q [$];
  int             err_cnt = 0;
  int             res_cnt = 0;

  function automatic logic handle_live(logic [HandleW-1:0] h);
    if (!region_present || h == '0 || h > NumHandles) return 1'b0;
    return slot_size_kb[AddrW'(h - 1'b1)] != '0;
  endfunction

  function automatic res_t apply_table_op(req_t r);
    res_t           res;
    int             slot;
    int             s;
    int             k;
    logic [KbW-1:0] off;
    logic [KbW-1:0] sz;
    logic [KbW-1:0] top_kb;
    logic [KbW-1:0] len;
    res  = '0;
    slot = -1;
    case (r.func)
      FnAlloc: begin
        if (region_present && used_kb <= capacity_kb &&
            r.size_kb <= capacity_kb - used_kb) begin
          for (k = 0; k < NumHandles; k++) begin
            if (slot < 0 && slot_size_kb[k] == '0) slot = k;
          end
          if (slot >= 0) begin
            slot_size_kb[slot]   = r.size_kb;
            slot_offset_kb[slot] = used_kb;
            used_kb              = used_kb + r.size_kb;
            res.ok               = 1'b1;
            res.handle_out       = HandleW'(slot + 1);
          end
        end
      end
      FnFree: begin
        if (handle_live(r.handle)) begin
          s      = int'(r.handle) - 1;
          off    = slot_offset_kb[s];
          sz     = slot_size_kb[s];
          top_kb = off + sz;
          len    = used_kb - top_kb;
          res.ok = 1'b1;
          if (len != '0) begin
            res.move_needed = 1'b1;
            res.move_src_kb = top_kb;
            res.move_dst_kb = off;
            res.move_len_kb = len;
          end
          used_kb         = used_kb - sz;
          slot_size_kb[s] = '0;
          for (k = 0; k < NumHandles; k++) begin
            if (slot_size_kb[k] != '0 && slot_offset_kb[k] > off) begin
              slot_offset_kb[k] = slot_offset_kb[k] - sz;
            end
          end
        end
      end
      FnQuery: begin
        res.total_kb_out = capacity_kb;
        res.free_kb      = (used_kb <= capacity_kb) ? capacity_kb - used_kb : '0;
      end
      default: begin
        res.ok = handle_live(r.handle);
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 50) $display("[%0t] cbs check: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int    k;
    res_t  exp_res;
    string diff;
    if (!rst_ni) begin
      for (k = 0; k < NumHandles; k++) begin
        slot_size_kb[k]   = '0;
        slot_offset_kb[k] = '0;
      end
      used_kb        = '0;
      region_present = 1'b0;
      capacity_kb    = '0;
      expected_res_q.delete();
      err_cnt        = 0;
      pending_o     <= 0;
      fail_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgRegionPresent) region_present = cfg_data_i[0];
        else capacity_kb = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        res_cnt++;
        if (expected_res_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", res_cnt));
        end else begin
          exp_res = expected_res_q.pop_front();
          diff    = "";
          if (out_i.ok !== exp_res.ok)
            diff = {diff, $sformatf(" ok %0h/%0h", out_i.ok, exp_res.ok)};
          if (out_i.handle_out !== exp_res.handle_out)
            diff = {diff, $sformatf(" handle_out %0h/%0h", out_i.handle_out,
                                    exp_res.handle_out)};
          if (out_i.total_kb_out !== exp_res.total_kb_out)
            diff = {diff, $sformatf(" total_kb %0h/%0h", out_i.total_kb_out,
                                    exp_res.total_kb_out)};
          if (out_i.free_kb !== exp_res.free_kb)
            diff = {diff, $sformatf(" free_kb %0h/%0h", out_i.free_kb, exp_res.free_kb)};
          if (out_i.move_needed !== exp_res.move_needed)
            diff = {diff, $sformatf(" move_needed %0h/%0h", out_i.move_needed,
                                    exp_res.move_needed)};
          if (out_i.move_src_kb !== exp_res.move_src_kb)
            diff = {diff, $sformatf(" move_src %0h/%0h", out_i.move_src_kb,
                                    exp_res.move_src_kb)};
          if (out_i.move_dst_kb !== exp_res.move_dst_kb)
            diff = {diff, $sformatf(" move_dst %0h/%0h", out_i.move_dst_kb,
                                    exp_res.move_dst_kb)};
          if (out_i.move_len_kb !== exp_res.move_len_kb)
            diff = {diff, $sformatf(" move_len %0h/%0h", out_i.move_len_kb,
                                    exp_res.move_len_kb)};
          if (diff != "") report_mismatch($sformatf("result %0d got/exp:%s", res_cnt, diff));
        end
      end
      if (in_valid_i && in_ready_i) expected_res_q.push_back(apply_table_op(in_i));
      pending_o    <= expected_res_q.size();
      fail_count_o <= err_cnt;
    end
  end

endmodule

### dv/tb_compacting_block_suballocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compacting_block_suballocator_core
// Drives the suballocator through directed corner cases, random phases with
// varied idling and capacity, a long output hold-off, a sweep that frees the
// low handles and a refill of them; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_compacting_block_suballocator_core;
  import cbs_pkg::*;

  localparam int ClkHalfNs     = 4;
  localparam int ResetCycles   = 11;
  localparam int StallLimit    = 20000;
  localparam int HoldOffCycles = 2500;
  localparam int SettleCycles  = 1100;
  localparam int PhaseItems    = 80;
  localparam int SweepHandles  = 32;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [KbW-1:0]     cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  req_t               in_i;
  logic               out_valid_o;
  logic               out_ready_i;
  res_t               out_o;

  int fail_count;
  int pending;
  int send_pct     = 0;
  int recv_pct     = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int alloc_issued = 0;

  always #(ClkHalfNs) clk_i = ~clk_i;

  compacting_block_suballocator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  cbs_alloc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_i         (in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_i        (out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_seq != hold_seen) begin
        hold_seen    = hold_seq;
        hold_left    = HoldOffCycles;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("compacting_block_suballocator_core: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic req_t mk_req(func_e f, logic [KbW-1:0] sz, logic [HandleW-1:0] h);
    req_t r;
    r.func    = f;
    r.size_kb = sz;
    r.handle  = h;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   pick;
    pick   = $urandom_range(0, 99);
    r.func = (pick < 35) ? FnAlloc : (pick < 65) ? FnFree : (pick < 80) ? FnQuery : FnVerify;
    pick   = $urandom_range(0, 99);
    if (pick < 55)      r.size_kb = KbW'($urandom_range(1, 64));
    else if (pick < 70) r.size_kb = '0;
    else if (pick < 82) r.size_kb = KbW'($urandom_range(65, 2047));
    else if (pick < 92) r.size_kb = KbW'($urandom_range(0, 65535));
    else                r.size_kb = '1;
    pick = $urandom_range(0, 99);
    if (pick < 80)      r.handle = HandleW'($urandom_range(1, 32));
    else if (pick < 87) r.handle = '0;
    else if (pick < 92) r.handle = HandleW'(NumHandles);
    else                r.handle = HandleW'($urandom_range(0, NumHandles));
    return r;
  endfunction

  task automatic send_item(input req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= r;
    if (r.func == FnAlloc) alloc_issued++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic present, input logic [KbW-1:0] cap);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgRegionPresent;
    cfg_data_i <= KbW'(present);
    @(posedge clk_i);
    cfg_idx_i  <= CfgCapacityKb;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int s_pct, input int r_pct, input bit pressure);
    int i;
    send_pct  = s_pct;
    recv_pct <= r_pct;
    for (i = 0; i < n; i++) begin
      if (pressure && i == n / 4) hold_seq <= hold_seq + 1;
      if (pressure && i == (3 * n) / 4) drain_results();
      send_item(rand_req());
    end
  endtask

  initial begin
    int n;
    int h;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgRegionPresent;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_i       = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(1'b0, '0);

    send_item(mk_req(FnAlloc, 16'd5, '0));
    send_item(mk_req(FnVerify, '0, 11'd1));
    send_item(mk_req(FnFree, '0, 11'd1));
    send_item(mk_req(FnQuery, '0, '0));
    drain_results();
    write_cfg(1'b1, 16'd100);
    send_item(mk_req(FnAlloc, '0, '0));
    send_item(mk_req(FnVerify, '0, 11'd1));
    send_item(mk_req(FnAlloc, 16'd10, '0));
    send_item(mk_req(FnAlloc, 16'd20, '0));
    send_item(mk_req(FnAlloc, 16'd30, '0));
    send_item(mk_req(FnAlloc, 16'd41, '0));
    send_item(mk_req(FnAlloc, 16'd40, '0));
    send_item(mk_req(FnQuery, '0, '0));
    send_item(mk_req(FnFree, '0, 11'd2));
    send_item(mk_req(FnVerify, '0, 11'd2));
    send_item(mk_req(FnFree, '0, 11'd4));
    send_item(mk_req(FnFree, '1, '0));
    send_item(mk_req(FnVerify, '0, 11'(NumHandles)));
    send_item(mk_req(FnAlloc, '1, '1));
    drain_results();
    write_cfg(1'b1, 16'd20);
    send_item(mk_req(FnQuery, '0, '0));
    send_item(mk_req(FnAlloc, '0, '0));
    drain_results();
    write_cfg(1'b1, '1);
    send_item(mk_req(FnFree, '0, 11'd1));
    send_item(mk_req(FnFree, '0, 11'd3));
    send_item(mk_req(FnAlloc, '1, '0));
    send_item(mk_req(FnFree, '0, 11'd1));

    drain_results();
    write_cfg(1'b1, '1);
    run_phase(PhaseItems, 0, 0, 1'b0);
    drain_results();
    write_cfg(1'b1, 16'd4096);
    run_phase(PhaseItems, 47, 0, 1'b0);
    drain_results();
    write_cfg(1'b1, KbW'($urandom_range(0, 600)));
    run_phase(PhaseItems, 0, 47, 1'b0);
    drain_results();
    write_cfg(1'b0, '1);
    run_phase(PhaseItems, 32, 32, 1'b0);
    drain_results();
    write_cfg(1'b1, KbW'($urandom_range(200, 3000)));
    run_phase(PhaseItems, 32, 32, 1'b0);
    drain_results();
    write_cfg(1'b1, '1);
    run_phase(PhaseItems, 0, 0, 1'b1);

    drain_results();
    write_cfg(1'b1, '1);
    send_pct  = 0;
    recv_pct <= 0;
    n = (alloc_issued < SweepHandles) ? alloc_issued : SweepHandles;
    for (h = 1; h <= n; h++) send_item(mk_req(FnFree, KbW'($urandom), HandleW'(h)));
    for (h = 0; h < SweepHandles; h++) begin
      send_item(mk_req(FnAlloc, KbW'($urandom_range(1, 63)),
                       HandleW'($urandom_range(0, NumHandles))));
    end
    send_item(mk_req(FnAlloc, 16'd1, '0));
    send_item(mk_req(FnQuery, '0, '0));
    send_item(mk_req(FnVerify, '0, 11'(NumHandles)));
    send_item(mk_req(FnFree, '0, 11'(NumHandles)));
    send_item(mk_req(FnFree, '0, 11'd1));
    send_item(mk_req(FnVerify, '0, 11'd1));

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("compacting_block_suballocator_core: match");
    end else begin
      $display("compacting_block_suballocator_core: mismatch");
    end
    $finish;
  end

endmodule
